// ===== design/fralu_pkg.sv =====
// Package for the four-register ALU with wrap carry.
// Holds widths, command and operation codes, and the item and queue types.
// Used by every module of the block; depends on nothing.
package fralu_pkg;

  localparam int DataBits   = 8;
  localparam int ResBits    = 16;
  localparam int ValBits    = ((2 * DataBits > ResBits) ? 2 * DataBits : ResBits) + 1;
  localparam int WrapLimit  = 255;
  localparam int CntBits    = $clog2(DataBits + 1);
  localparam int QueueDepth = 2;
  localparam int QPtrBits   = $clog2(QueueDepth);
  localparam int QCntBits   = $clog2(QueueDepth + 1);

  localparam logic [1:0] CmdWrite   = 2'd0;
  localparam logic [1:0] CmdOperate = 2'd1;
  localparam logic [1:0] CmdReadReg = 2'd2;
  localparam logic [1:0] CmdReadRes = 2'd3;

  localparam logic [2:0] OpAdd = 3'd0;
  localparam logic [2:0] OpSub = 3'd1;
  localparam logic [2:0] OpMul = 3'd2;
  localparam logic [2:0] OpDiv = 3'd3;

  typedef logic [DataBits-1:0] operand_t;

  typedef enum logic [2:0] {
    K_WRITE,
    K_READ_REG,
    K_READ_RES,
    K_ADD,
    K_SUB,
    K_MUL,
    K_DIV,
    K_HOLD
  } kind_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] reg_index;
    logic [7:0] write_value;
    logic [2:0] first_sel;
    logic [2:0] second_sel;
    logic [2:0] op_code;
  } req_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        carry_out;
    logic        div_zero;
    logic        bad_request;
  } rsp_t;

  // Decoded item as it waits in the queue between front and back.
  typedef struct packed {
    kind_t      kind;
    logic [1:0] reg_index;
    logic [7:0] write_value;
    logic [1:0] a_idx;
    logic       a_ok;
    logic [1:0] b_idx;
    logic       b_ok;
    logic       bad;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== design/four_register_alu_with_wrap_carry_unit.sv =====
// Top level of the four-register ALU with wrap carry.
// Instantiates fralu_front, fralu_queue and fralu_back; depends on fralu_pkg.
//
// Each request item yields exactly one response item, in order. The front
// decodes items into a two-entry queue, so new items are taken while the back
// works or while a response waits in the output register. The back takes one
// item at a time: a register write goes straight to the output register, a
// register or result read passes the execute step, and add, subtract,
// multiply, divide by zero and an invalid operation pass the execute and
// adjust steps; a divide also runs the one-bit-a-cycle restoring divider
// between them. The back takes no new item until the output register is taken.
module four_register_alu_with_wrap_carry_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  fralu_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output fralu_pkg::rsp_t rsp
);
  import fralu_pkg::*;

  q_status_t qstat;
  entry_t    wr_entry;
  entry_t    head;
  logic      push;
  logic      pop;

  fralu_front u_front (
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .qstat     (qstat),
    .push      (push),
    .entry     (wr_entry)
  );

  fralu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .head     (head),
    .status   (qstat)
  );

  fralu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .qstat     (qstat),
    .head      (head),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// ===== design/fralu_front.sv =====
// Front end: accepts request items and classifies them into queue entries.
// Depends on fralu_pkg.
module fralu_front (
  input  logic                 req_valid,
  output logic                 req_ready,
  input  fralu_pkg::req_t      req,
  input  fralu_pkg::q_status_t qstat,
  output logic                 push,
  output fralu_pkg::entry_t    entry
);
  import fralu_pkg::*;

  logic op_bad;

  assign req_ready = !qstat.full;
  assign push      = req_valid && req_ready;

  always_comb begin
    entry             = '0;
    entry.reg_index   = req.reg_index;
    entry.write_value = req.write_value;
    // A selector of four or more is invalid and reads as zero.
    entry.a_idx       = req.first_sel[1:0];
    entry.a_ok        = !req.first_sel[2];
    entry.b_idx       = req.second_sel[1:0];
    entry.b_ok        = !req.second_sel[2];
    op_bad            = 1'b0;
    entry.kind        = K_HOLD;
    unique case (req.cmd)
      CmdWrite:   entry.kind = K_WRITE;
      CmdReadReg: entry.kind = K_READ_REG;
      CmdReadRes: entry.kind = K_READ_RES;
      CmdOperate: begin
        unique case (req.op_code)
          OpAdd:   entry.kind = K_ADD;
          OpSub:   entry.kind = K_SUB;
          OpMul:   entry.kind = K_MUL;
          OpDiv:   entry.kind = K_DIV;
          default: begin
            entry.kind = K_HOLD;
            op_bad     = 1'b1;
          end
        endcase
      end
      default: entry.kind = K_HOLD;
    endcase
    entry.bad = (req.cmd == CmdOperate) &&
                (op_bad || req.first_sel[2] || req.second_sel[2]);
  end

endmodule

// ===== design/fralu_queue.sv =====
// Short queue of decoded items between the front and the back.
// Depends on fralu_pkg.
module fralu_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  fralu_pkg::entry_t    wr_entry,
  input  logic                 pop,
  output fralu_pkg::entry_t    head,
  output fralu_pkg::q_status_t status
);
  import fralu_pkg::*;

  entry_t              slots [QueueDepth];
  logic [QPtrBits-1:0] wr_ptr;
  logic [QPtrBits-1:0] rd_ptr;
  logic [QCntBits-1:0] count;

  assign head         = slots[rd_ptr];
  assign status.full  = (count == QCntBits'(QueueDepth));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPtrBits'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPtrBits'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/fralu_back.sv =====
// Back end: operand registers, result and carry, arithmetic, iterative divider
// and the output register. Depends on fralu_pkg.
module fralu_back (
  input  logic                 clk,
  input  logic                 rst,
  input  fralu_pkg::q_status_t qstat,
  input  fralu_pkg::entry_t    head,
  output logic                 pop,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output fralu_pkg::rsp_t      rsp
);
  import fralu_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DIV  = 4'b0100,
    S_ADJ  = 4'b1000
  } bstate_t;

  bstate_t              state;
  entry_t               cur;
  operand_t             mem [4];
  logic [3:0]           vld;
  operand_t             rd1;
  operand_t             rd2;
  logic                 rd1_vld;
  logic                 rd2_vld;
  logic [ResBits-1:0]   result_reg;
  logic                 carry;
  logic [ValBits-1:0]   val;
  logic                 neg;
  logic                 dz;
  operand_t             quo;
  operand_t             rem;
  logic [CntBits-1:0]   cnt;

  operand_t             a;
  operand_t             b;
  logic [2*DataBits-1:0] prod;
  logic [DataBits:0]    trial;
  logic [ValBits-1:0]   adj_in;
  logic [ValBits-1:0]   adj_out;
  logic                 carry_next;
  logic [1:0]           addr1;
  rsp_t                 rsp_next;

  assign pop   = (state == S_IDLE) && !qstat.empty && !rsp_valid;
  assign addr1 = (head.kind == K_READ_REG) ? head.reg_index : head.a_idx;

  // Operand registers: one write port and two registered read ports. An entry
  // never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (pop && head.kind == K_WRITE) begin
      mem[head.reg_index] <= DataBits'(head.write_value);
    end
    if (pop) begin
      rd1     <= mem[addr1];
      rd2     <= mem[head.b_idx];
      rd1_vld <= vld[addr1];
      rd2_vld <= vld[head.b_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (pop && head.kind == K_WRITE) begin
      vld[head.reg_index] <= 1'b1;
    end
  end

  assign a     = (rd1_vld && cur.a_ok) ? rd1 : '0;
  assign b     = (rd2_vld && cur.b_ok) ? rd2 : '0;
  assign prod  = (2*DataBits)'(a) * (2*DataBits)'(b);
  assign trial = {rem, quo[DataBits-1]};

  // The quotient is taken straight from the divider when it finishes.
  always_comb begin
    adj_in = (cur.kind == K_DIV && !dz) ? ValBits'(quo) : val;
    if (neg) begin
      adj_out    = ValBits'(WrapLimit) - val;
      carry_next = 1'b1;
    end else if (adj_in > ValBits'(WrapLimit)) begin
      adj_out    = adj_in - ValBits'(WrapLimit);
      carry_next = 1'b1;
    end else begin
      adj_out    = adj_in;
      carry_next = 1'b0;
    end
  end

  // Response fields for the current step; the adjust step carries the flags.
  always_comb begin
    rsp_next           = '0;
    rsp_next.carry_out = carry;
    if (state == S_EXEC) begin
      if (cur.kind == K_READ_REG) begin
        rsp_next.read_data = ResBits'(rd1_vld ? rd1 : '0);
      end else begin
        rsp_next.read_data = result_reg;
      end
    end
    if (state == S_ADJ) begin
      rsp_next.carry_out   = carry_next;
      rsp_next.div_zero    = dz;
      rsp_next.bad_request = cur.bad;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (state == S_EXEC) begin
      neg <= (cur.kind == K_SUB) && (a < b);
      dz  <= (cur.kind == K_DIV) && (b == '0);
      case (cur.kind)
        K_ADD: val <= ValBits'(a) + ValBits'(b);
        K_SUB: val <= (a < b) ? ValBits'(b - a) : ValBits'(a - b);
        K_MUL: val <= ValBits'(prod);
        K_DIV: begin
          if (b == '0) begin
            val <= ValBits'(result_reg);
          end
          quo <= a;
          rem <= '0;
          cnt <= '0;
        end
        default: val <= ValBits'(result_reg);
      endcase
    end
    if (state == S_DIV) begin
      if (trial >= {1'b0, b}) begin
        rem <= DataBits'(trial - {1'b0, b});
        quo <= {quo[DataBits-2:0], 1'b1};
      end else begin
        rem <= trial[DataBits-1:0];
        quo <= {quo[DataBits-2:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
    end
    if (pop || state == S_EXEC || state == S_ADJ) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      result_reg <= '0;
      carry      <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            if (head.kind == K_WRITE) begin
              rsp_valid <= 1'b1;
            end else begin
              state <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          if (cur.kind == K_READ_REG || cur.kind == K_READ_RES) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end else if (cur.kind == K_DIV && b != '0) begin
            state <= S_DIV;
          end else begin
            state <= S_ADJ;
          end
        end
        S_DIV: begin
          if (cnt == CntBits'(DataBits - 1)) begin
            state <= S_ADJ;
          end
        end
        S_ADJ: begin
          result_reg <= ResBits'(adj_out);
          carry      <= carry_next;
          rsp_valid  <= 1'b1;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_adj_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADJ) |=> (rsp_valid && state == S_IDLE))
    else $error("operate item did not reach the output register");

  a_carry_only_on_adjust: assert property (@(posedge clk) disable iff (rst)
    !$past(state == S_ADJ) |-> ($stable(carry) && $stable(result_reg)))
    else $error("result or carry changed outside the adjust step");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (cur.kind == K_DIV && b != '0))
    else $error("divider running without a nonzero divide item");

endmodule
